[rtl/core/ptda_pkg.sv]
// ----------------------------------------------------------------------------
// ptda_pkg
// Shared types, codes and the dimension order table of the plane to
// directory assigner.
// ----------------------------------------------------------------------------
package ptda_pkg;

    localparam int MAX_DIRS_DEF   = 1024;
    localparam int COORD_BITS_DEF = 8;

    localparam int FUNC_W   = 2;
    localparam int DIR_W    = 10;
    localparam int FIRST_W  = 8;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int ODIR_W   = 11;
    localparam int OCRD_W   = 9;
    localparam int ORDER_W  = 3;
    localparam int SIZE_W   = 9;
    localparam int DCOUNT_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZSIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TSIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CSIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DCOUNT = 3'd4;

    localparam logic [ORDER_W-1:0] ORD_ZCT = 3'd0;
    localparam logic [ORDER_W-1:0] ORD_ZTC = 3'd1;
    localparam logic [ORDER_W-1:0] ORD_CTZ = 3'd2;
    localparam logic [ORDER_W-1:0] ORD_CZT = 3'd3;
    localparam logic [ORDER_W-1:0] ORD_TCZ = 3'd4;
    localparam logic [ORDER_W-1:0] ORD_TZC = 3'd5;

    localparam logic [1:0] DIG_Z = 2'd0;
    localparam logic [1:0] DIG_T = 2'd1;
    localparam logic [1:0] DIG_C = 2'd2;

    // element 0 is the fastest digit
    typedef logic [2:0][1:0] order_t;

    typedef struct packed {
        logic load;
        logic step;
        logic read_res;
        logic res_zero;
        logic wipe;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic wipe_last;
    } sts_t;

    function automatic order_t digit_order(input logic [ORDER_W-1:0] code);
        order_t od;
        unique case (code)
            ORD_ZCT: od = {DIG_T, DIG_C, DIG_Z};
            ORD_ZTC: od = {DIG_C, DIG_T, DIG_Z};
            ORD_CTZ: od = {DIG_Z, DIG_T, DIG_C};
            ORD_CZT: od = {DIG_T, DIG_Z, DIG_C};
            ORD_TCZ: od = {DIG_Z, DIG_C, DIG_T};
            ORD_TZC: od = {DIG_C, DIG_Z, DIG_T};
            default: od = {DIG_T, DIG_C, DIG_Z};
        endcase
        return od;
    endfunction

endpackage

[rtl/core/ptda_ctrl.sv]
// ----------------------------------------------------------------------------
// ptda_ctrl
// Sequencer of the assigner: clearing sweep, record walk, entry read and
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module ptda_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [ptda_pkg::FUNC_W-1:0]   func,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  ptda_pkg::sts_t                sts,
    output ptda_pkg::cmd_t                cmd
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WIPE  = 3'd4;
    localparam logic [2:0] S_REPLY = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.wipe = 1'b1;
                if (sts.wipe_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (func)
                        ptda_pkg::FUNC_APPLY: state_next = S_WALK;
                        ptda_pkg::FUNC_READ:  state_next = S_READ;
                        ptda_pkg::FUNC_CLEAR: state_next = S_WIPE;
                        default:
                        begin
                            cmd.res_zero = 1'b1;
                            state_next   = S_REPLY;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_REPLY;
                end
            end
            S_READ:
            begin
                cmd.read_res = 1'b1;
                state_next   = S_REPLY;
            end
            S_WIPE:
            begin
                cmd.wipe = 1'b1;
                if (sts.wipe_last)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[rtl/core/ptda_dpath.sv]
// ----------------------------------------------------------------------------
// ptda_dpath
// Datapath of the assigner: configuration registers, directory table,
// Z/T/C walk counter, checks and result registers.
// ----------------------------------------------------------------------------
module ptda_dpath
#(
    parameter int MAX_DIRS   = ptda_pkg::MAX_DIRS_DEF,
    parameter int COORD_BITS = ptda_pkg::COORD_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ptda_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptda_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [ptda_pkg::DIR_W-1:0]        directory,
    input  logic [ptda_pkg::FIRST_W-1:0]      first_z,
    input  logic [ptda_pkg::FIRST_W-1:0]      first_t,
    input  logic [ptda_pkg::FIRST_W-1:0]      first_c,
    input  logic [ptda_pkg::COUNT_W-1:0]      plane_count,
    input  ptda_pkg::cmd_t                    cmd,
    output ptda_pkg::sts_t                    sts,
    output logic [ptda_pkg::STATUS_W-1:0]     status,
    output logic [ptda_pkg::ODIR_W-1:0]       out_dir,
    output logic [ptda_pkg::OCRD_W-1:0]       out_z,
    output logic [ptda_pkg::OCRD_W-1:0]       out_t,
    output logic [ptda_pkg::OCRD_W-1:0]       out_c,
    output logic                              out_seen
);

    localparam int AW = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
    localparam int CW = ($clog2(MAX_DIRS + 1) > ptda_pkg::COUNT_W) ?
                        $clog2(MAX_DIRS + 1) : ptda_pkg::COUNT_W;
    localparam int VW = (COORD_BITS + 1 > ptda_pkg::OCRD_W) ?
                        COORD_BITS + 1 : ptda_pkg::OCRD_W;
    localparam int MW = 3 * COORD_BITS + 1;
    localparam logic [VW-1:0] SIZE_LIM  = VW'(2 ** COORD_BITS);
    localparam logic [CW-1:0] DIR_LIM   = CW'(MAX_DIRS);
    localparam logic [AW-1:0] WIPE_LAST = AW'(MAX_DIRS - 1);
    localparam int OW = ptda_pkg::OCRD_W;

    // configuration
    logic [ptda_pkg::ORDER_W-1:0]  order_reg;
    logic [ptda_pkg::SIZE_W-1:0]   zsize_reg;
    logic [ptda_pkg::SIZE_W-1:0]   tsize_reg;
    logic [ptda_pkg::SIZE_W-1:0]   csize_reg;
    logic [ptda_pkg::DCOUNT_W-1:0] dcount_reg;

    // walk
    logic [2:0][VW-1:0]      v_reg;
    logic [2:0][VW-1:0]      v_next;
    logic [2:0][VW-1:0]      first_reg;
    logic [2:0][VW-1:0]      v_inc;
    logic [2:0][VW-1:0]      sz;
    logic [CW-1:0]           ifd_reg;
    logic [CW-1:0]           ifd_inc;
    logic [CW-1:0]           dir_ext;
    logic [CW-1:0]           cnt;
    logic [ptda_pkg::COUNT_W-1:0] rem_reg;
    ptda_pkg::order_t        od;

    // table
    logic [MW-1:0]           mem [MAX_DIRS];
    logic [MW-1:0]           rdata_reg;
    logic [MW-1:0]           wdata;
    logic [AW-1:0]           raddr;
    logic [AW-1:0]           wipe_addr_reg;
    logic                    ent_seen;
    logic [2:0][VW-1:0]      ent_ext;

    // checks
    logic                    rem_zero;
    logic                    fail_coord;
    logic                    fail_dir;
    logic                    mismatch;
    logic                    walk_fail;
    logic                    step_ok;
    logic                    rd_in_range;
    logic                    rd_seen;
    logic [ptda_pkg::STATUS_W-1:0] fail_code;

    // pending and output result
    logic [ptda_pkg::STATUS_W-1:0] res_status_reg;
    logic [ptda_pkg::ODIR_W-1:0]   res_dir_reg;
    logic [2:0][OW-1:0]            res_crd_reg;
    logic                          res_seen_reg;
    logic [ptda_pkg::STATUS_W-1:0] status_reg;
    logic [ptda_pkg::ODIR_W-1:0]   out_dir_reg;
    logic [2:0][OW-1:0]            out_crd_reg;
    logic                          out_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= ptda_pkg::ORD_ZCT;
            zsize_reg  <= 9'd1;
            tsize_reg  <= 9'd1;
            csize_reg  <= 9'd1;
            dcount_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ptda_pkg::REG_ORDER:  order_reg  <= cfg_data[ptda_pkg::ORDER_W-1:0];
                ptda_pkg::REG_ZSIZE:  zsize_reg  <= cfg_data[ptda_pkg::SIZE_W-1:0];
                ptda_pkg::REG_TSIZE:  tsize_reg  <= cfg_data[ptda_pkg::SIZE_W-1:0];
                ptda_pkg::REG_CSIZE:  csize_reg  <= cfg_data[ptda_pkg::SIZE_W-1:0];
                ptda_pkg::REG_DCOUNT: dcount_reg <= cfg_data[ptda_pkg::DCOUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sizes clamp to the coordinate range, count to the table depth
    always_comb
    begin
        sz[0] = (VW'(zsize_reg) > SIZE_LIM) ? SIZE_LIM : VW'(zsize_reg);
        sz[1] = (VW'(tsize_reg) > SIZE_LIM) ? SIZE_LIM : VW'(tsize_reg);
        sz[2] = (VW'(csize_reg) > SIZE_LIM) ? SIZE_LIM : VW'(csize_reg);
        cnt   = (CW'(dcount_reg) > DIR_LIM) ? DIR_LIM : CW'(dcount_reg);
    end

    assign od      = ptda_pkg::digit_order(order_reg);
    assign dir_ext = CW'(directory);
    assign ifd_inc = ifd_reg + CW'(1);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_inc[i]   = v_reg[i] + VW'(1);
            ent_ext[i] = VW'(rdata_reg[i*COORD_BITS +: COORD_BITS]);
        end
    end

    assign ent_seen = rdata_reg[MW-1];

    // nested counter, inner digits wrap to their first value
    always_comb
    begin
        v_next = v_reg;
        if (v_inc[od[0]] == sz[od[0]])
        begin
            v_next[od[0]] = first_reg[od[0]];
            if (v_inc[od[1]] == sz[od[1]])
            begin
                v_next[od[1]] = first_reg[od[1]];
                v_next[od[2]] = v_inc[od[2]];
            end
            else
            begin
                v_next[od[1]] = v_inc[od[1]];
            end
        end
        else
        begin
            v_next[od[0]] = v_inc[od[0]];
        end
    end

    assign rem_zero   = (rem_reg == '0);
    assign fail_coord = (v_reg[0] >= sz[0]) || (v_reg[1] >= sz[1]) || (v_reg[2] >= sz[2]);
    assign fail_dir   = (ifd_reg >= cnt);
    assign mismatch   = ent_seen && ((ent_ext[0] != v_reg[0]) ||
                                     (ent_ext[1] != v_reg[1]) ||
                                     (ent_ext[2] != v_reg[2]));
    assign walk_fail  = fail_coord || fail_dir || mismatch;
    assign step_ok    = cmd.step && !rem_zero && !walk_fail;

    always_comb
    begin
        priority if (fail_coord)
        begin
            fail_code = ptda_pkg::ST_RANGE;
        end
        else if (fail_dir)
        begin
            fail_code = ptda_pkg::ST_BEYOND;
        end
        else
        begin
            fail_code = ptda_pkg::ST_CONFLICT;
        end
    end

    assign sts.walk_done = rem_zero || walk_fail;
    assign sts.wipe_last = (wipe_addr_reg == WIPE_LAST);

    assign rd_in_range = (ifd_reg < DIR_LIM);
    assign rd_seen     = rd_in_range && ent_seen;

    assign wdata = {1'b1, v_reg[2][COORD_BITS-1:0], v_reg[1][COORD_BITS-1:0],
                    v_reg[0][COORD_BITS-1:0]};
    // next entry is fetched while the current one is checked and written
    assign raddr = cmd.load ? dir_ext[AW-1:0] : ifd_inc[AW-1:0];

    always_ff @(posedge clk)
    begin
        priority if (cmd.wipe)
        begin
            mem[wipe_addr_reg] <= '0;
        end
        else if (step_ok)
        begin
            mem[ifd_reg[AW-1:0]] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_addr_reg <= '0;
        end
        else if (cmd.wipe)
        begin
            wipe_addr_reg <= sts.wipe_last ? '0 : wipe_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.load)
        begin
            v_reg     <= {VW'(first_c), VW'(first_t), VW'(first_z)};
            first_reg <= {VW'(first_c), VW'(first_t), VW'(first_z)};
            ifd_reg   <= dir_ext;
            rem_reg   <= plane_count;
        end
        else if (step_ok)
        begin
            v_reg   <= v_next;
            ifd_reg <= ifd_inc;
            rem_reg <= rem_reg - ptda_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.res_zero || (cmd.step && rem_zero))
        begin
            res_status_reg <= ptda_pkg::ST_OK;
            res_dir_reg    <= '0;
            res_crd_reg    <= '0;
            res_seen_reg   <= 1'b0;
        end
        else if (cmd.read_res)
        begin
            res_status_reg <= ptda_pkg::ST_OK;
            res_dir_reg    <= ifd_reg[ptda_pkg::ODIR_W-1:0];
            res_seen_reg   <= rd_seen;
            for (int i = 0; i < 3; i++)
            begin
                res_crd_reg[i] <= rd_seen ? ent_ext[i][OW-1:0] : '0;
            end
        end
        else if (cmd.step && walk_fail)
        begin
            res_status_reg <= fail_code;
            res_dir_reg    <= ifd_reg[ptda_pkg::ODIR_W-1:0];
            res_seen_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                res_crd_reg[i] <= v_reg[i][OW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg   <= res_status_reg;
            out_dir_reg  <= res_dir_reg;
            out_crd_reg  <= res_crd_reg;
            out_seen_reg <= res_seen_reg;
        end
    end

    assign status   = status_reg;
    assign out_dir  = out_dir_reg;
    assign out_z    = out_crd_reg[0];
    assign out_t    = out_crd_reg[1];
    assign out_c    = out_crd_reg[2];
    assign out_seen = out_seen_reg;

endmodule

[rtl/core/plane_to_directory_assigner.sv]
// ----------------------------------------------------------------------------
// plane_to_directory_assigner
// Assigns Z/T/C plane coordinates to image directories and answers reads.
//
// Request channel (req_valid/req_stall) carries func, directory, first_z,
// first_t, first_c and plane_count; one transfer per item. The response
// channel (rsp_valid/rsp_stall) returns one result per item from an output
// register. The block works on one item at a time.
// From request transfer to rsp_valid: an apply record does one table
// read-modify-write per plane walked, the next entry fetched while the
// current one is checked; a read fetches one entry and registers it; a
// clear wipes one table row per cycle. The next request is taken the cycle
// after the result is loaded into the output register.
// After reset the whole table is swept with req_stall high;
// configuration writes (cfg_write, cfg_index, cfg_data) are taken at any time.
// A stalled response holds its value; the request side can take one more
// item while it waits, which then waits until the output register frees.
// ----------------------------------------------------------------------------
module plane_to_directory_assigner
#(
    parameter int MAX_DIRS   = ptda_pkg::MAX_DIRS_DEF,
    parameter int COORD_BITS = ptda_pkg::COORD_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ptda_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptda_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [ptda_pkg::FUNC_W-1:0]       func,
    input  logic [ptda_pkg::DIR_W-1:0]        directory,
    input  logic [ptda_pkg::FIRST_W-1:0]      first_z,
    input  logic [ptda_pkg::FIRST_W-1:0]      first_t,
    input  logic [ptda_pkg::FIRST_W-1:0]      first_c,
    input  logic [ptda_pkg::COUNT_W-1:0]      plane_count,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [ptda_pkg::STATUS_W-1:0]     status,
    output logic [ptda_pkg::ODIR_W-1:0]       out_dir,
    output logic [ptda_pkg::OCRD_W-1:0]       out_z,
    output logic [ptda_pkg::OCRD_W-1:0]       out_t,
    output logic [ptda_pkg::OCRD_W-1:0]       out_c,
    output logic                              out_seen
);

    ptda_pkg::cmd_t cmd;
    ptda_pkg::sts_t sts;

    ptda_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ptda_dpath
    #(
        .MAX_DIRS   (MAX_DIRS),
        .COORD_BITS (COORD_BITS)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .directory   (directory),
        .first_z     (first_z),
        .first_t     (first_t),
        .first_c     (first_c),
        .plane_count (plane_count),
        .cmd         (cmd),
        .sts         (sts),
        .status      (status),
        .out_dir     (out_dir),
        .out_z       (out_z),
        .out_t       (out_t),
        .out_c       (out_c),
        .out_seen    (out_seen)
    );

endmodule

[rtl/core/ptda_port_checker.sv]
// ----------------------------------------------------------------------------
// ptda_port_checker
// Port level checks of the assigner, bound to the top level.
// ----------------------------------------------------------------------------
module ptda_port_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [ptda_pkg::STATUS_W-1:0] status,
    input logic [ptda_pkg::ODIR_W-1:0]   out_dir,
    input logic                          out_seen
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(out_dir))
        else $error("stalled response changed");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while an item is in work");

    a_seen_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && out_seen |-> status == ptda_pkg::ST_OK)
        else $error("seen entry reported with an error status");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> req_stall && !rsp_valid)
        else $error("channels active during reset");

endmodule

bind plane_to_directory_assigner ptda_port_checker u_port_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .out_dir   (out_dir),
    .out_seen  (out_seen)
);
